FILE: hdl/alfp_pkg.sv
package alfp_pkg;

	// Default generator geometry (trinomial x^31 + x^3 + 1)
	localparam int DEGREE_DEF     = 31;
	localparam int SEPARATION_DEF = 3;
	localparam int WARMUP_DEF     = 10;

	// Word widths
	localparam int WORD_W  = 32;
	localparam int VALUE_W = 31;

	// Input item kind, carried in tuser
	typedef enum logic {
		MODE_SEED = 1'b0,
		MODE_DRAW = 1'b1
	} mode_t;

	// Minimal Standard LCG: w' = 16807 * w mod (2^31 - 1)
	localparam int          LCG_MULT_W = 15;
	localparam logic [14:0] LCG_MULT   = 15'd16807;
	localparam logic [30:0] LCG_MOD    = 31'h7FFF_FFFF;
	// Twice the modulus, added so that a negative first seed word folds correctly
	localparam logic [33:0] LCG_MOD_X2 = 34'h0_FFFF_FFFE;
	localparam int          PROD_W     = 48;

endpackage

FILE: hdl/alfp_lcg.sv
// Minimal Standard LCG step: multiply (registered), then
// fold modulo 2^31 - 1. Equal to Schrage's form for every signed 32-bit word.
module alfp_lcg (
	input  logic        clk,
	input  logic        load,    // capture w_in and multiply
	input  logic [31:0] w_in,    // current word, taken as signed
	output logic [30:0] result   // next word, valid the cycle after load
);

	logic [33:0] u_ext;
	logic [32:0] u;
	logic [alfp_pkg::PROD_W-1:0] prod_q;
	logic [30:0] p_lo;
	logic [16:0] p_hi;
	logic [31:0] s;
	logic [31:0] t;

	// shift a possibly negative word into [0, 2^33) without changing its residue
	assign u_ext = {{2{w_in[31]}}, w_in} + alfp_pkg::LCG_MOD_X2;
	assign u     = u_ext[32:0];

	// multiply stage
	always_ff @(posedge clk) begin
		if (load) begin
			prod_q <= alfp_pkg::PROD_W'(u) * alfp_pkg::PROD_W'(alfp_pkg::LCG_MULT);
		end
	end

	// fold: 2^31 == 1 modulo the Mersenne prime
	assign p_lo = prod_q[30:0];
	assign p_hi = prod_q[47:31];
	assign s    = 32'(p_lo) + 32'(p_hi);
	assign t    = 32'(s[30:0]) + 32'(s[31]);
	assign result = (t[30:0] == alfp_pkg::LCG_MOD) ? 31'd0 : t[30:0];

endmodule

FILE: hdl/alfp_lag_ram.sv
// Lag table: one write port, two read ports with registered data.
module alfp_lag_ram #(
	parameter int DEPTH = alfp_pkg::DEGREE_DEF,
	parameter int AW    = $clog2(alfp_pkg::DEGREE_DEF)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [alfp_pkg::WORD_W-1:0] wdata,
	input  logic [AW-1:0]              raddr_a,
	input  logic [AW-1:0]              raddr_b,
	output logic [alfp_pkg::WORD_W-1:0] rdata_a,
	output logic [alfp_pkg::WORD_W-1:0] rdata_b
);

	logic [alfp_pkg::WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

FILE: hdl/additive_lagged_fibonacci_prng_core.sv
// Additive lagged Fibonacci generator (x^31 + x^3 + 1 by default). An input item
// with tuser = 1 draws: the rear word is added into the front word modulo 2^32,
// both cursors advance, and the sum shifted right by one comes out as a 31-bit
// item. A draw passes through a registered two-port read of the lag table, then
// the add and write-back, which waits while an earlier result on the output has
// not been taken; the result is then registered for output and tready rises again.
// An input item with tuser = 0 reseeds from tdata (0 acts as 1) and gives no
// output: the table is filled by one shared LCG multiply/fold unit, one word
// after another, then DEGREE*WARMUP_FACTOR draws are discarded. After reset the
// same sequence runs with seed 1 before tready rises. A new item may be accepted
// while an earlier result waits on the output.
module additive_lagged_fibonacci_prng_core #(
	parameter int DEGREE        = alfp_pkg::DEGREE_DEF,
	parameter int SEPARATION    = alfp_pkg::SEPARATION_DEF,
	parameter int WARMUP_FACTOR = alfp_pkg::WARMUP_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] seed
	input  logic [0:0]  s_axis_tuser,   // [0] mode (0 reseed, 1 draw)
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata    // [30:0] value, [31] zero
);

	localparam int AW         = $clog2(DEGREE);
	localparam int SEP_IDX    = (SEPARATION < DEGREE) ? SEPARATION : 0;
	localparam int WARM_COUNT = DEGREE * WARMUP_FACTOR;
	localparam int CW         = $clog2(WARM_COUNT + 2);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SEED = 6'b000010,
		S_MUL  = 6'b000100,
		S_FOLD = 6'b001000,
		S_RD   = 6'b010000,
		S_SUM  = 6'b100000
	} state_t;

	state_t        state_q;
	logic [31:0]   w_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] front_q;
	logic [AW-1:0] rear_q;
	logic [AW-1:0] front_nx;
	logic [AW-1:0] rear_nx;
	logic [CW-1:0] cnt_q;
	logic          warm_q;
	logic          out_valid_q;
	logic [30:0]   value_q;

	logic          accept;
	logic          out_free;
	logic          draw_done;
	logic          lcg_load;
	logic [30:0]   lcg_res;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [31:0]   ram_wdata;
	logic [31:0]   rd_front;
	logic [31:0]   rd_rear;
	logic [31:0]   sum;
	logic [AW:0]   rear_sep;
	logic [AW-1:0] front_exp;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign out_free      = !out_valid_q || m_axis_tready;
	assign draw_done     = (state_q == S_SUM) && !warm_q && out_free;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, value_q};

	// cursor advance with wrap
	assign front_nx = (front_q == AW'(DEGREE - 1)) ? '0 : front_q + AW'(1);
	assign rear_nx  = (rear_q == AW'(DEGREE - 1)) ? '0 : rear_q + AW'(1);

	assign sum = rd_front + rd_rear;

	// shared LCG unit
	assign lcg_load = (state_q == S_MUL);

	alfp_lcg u_lcg (
		.clk    (clk),
		.load   (lcg_load),
		.w_in   (w_q),
		.result (lcg_res)
	);

	// table write port source
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = front_q;
		ram_wdata = sum;
		unique case (state_q)
			S_SEED: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = w_q;
			end
			S_FOLD: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = {1'b0, lcg_res};
			end
			S_SUM: begin
				ram_we = warm_q || out_free;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	alfp_lag_ram #(
		.DEPTH (DEGREE),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (front_q),
		.raddr_b (rear_q),
		.rdata_a (rd_front),
		.rdata_b (rd_rear)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SEED;
			w_q         <= 32'd1;
			idx_q       <= '0;
			front_q     <= '0;
			rear_q      <= '0;
			cnt_q       <= '0;
			warm_q      <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (s_axis_tuser[0] == alfp_pkg::MODE_DRAW) begin
							state_q <= S_RD;
						end else begin
							w_q     <= (s_axis_tdata == 32'd0) ? 32'd1 : s_axis_tdata;
							state_q <= S_SEED;
						end
					end
				end
				S_SEED: begin
					idx_q   <= AW'(1);
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_FOLD;
				end
				S_FOLD: begin
					w_q <= {1'b0, lcg_res};
					if (idx_q == AW'(DEGREE - 1)) begin
						front_q <= AW'(SEP_IDX);
						rear_q  <= '0;
						cnt_q   <= CW'(WARM_COUNT);
						if (WARM_COUNT == 0) begin
							state_q <= S_IDLE;
						end else begin
							warm_q  <= 1'b1;
							state_q <= S_RD;
						end
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= S_MUL;
					end
				end
				S_RD: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (warm_q) begin
						front_q <= front_nx;
						rear_q  <= rear_nx;
						cnt_q   <= cnt_q - CW'(1);
						if (cnt_q == CW'(1)) begin
							warm_q  <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_RD;
						end
					end else if (out_free) begin
						front_q     <= front_nx;
						rear_q      <= rear_nx;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output valid: set by a finished draw, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (draw_done) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output item
	always_ff @(posedge clk) begin
		if (draw_done) begin
			value_q <= sum[31:1];
		end
	end

	// expected front cursor given the rear cursor
	assign rear_sep  = (AW + 1)'(rear_q) + (AW + 1)'(SEP_IDX);
	assign front_exp = (rear_sep >= (AW + 1)'(DEGREE)) ?
		AW'(rear_sep - (AW + 1)'(DEGREE)) : rear_sep[AW-1:0];

`ifndef NO_ASSERTIONS
	// cursors keep their fixed separation between items
	a_cursor_sep: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (front_q == front_exp))
		else $error("front/rear cursor separation lost");

	// warm-up runs only through the draw states
	a_warm_states: assert property (@(posedge clk) disable iff (!arst_n)
		warm_q |-> (state_q == S_RD || state_q == S_SUM))
		else $error("warm-up flag outside draw states");

	// no warm-up draws pending when accepting
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (cnt_q == '0 && !warm_q))
		else $error("ready with warm-up pending");

	// a completed user draw raises the output
	a_draw_out: assert property (@(posedge clk) disable iff (!arst_n)
		draw_done |=> m_axis_tvalid)
		else $error("draw result not presented");
`endif

endmodule
